// ===== src/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier extrema package
// Shared constants, widths and register codes for the extrema finder.
// ----------------------------------------------------------------------------
package cbe_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned COORD_WIDTH_DEF = 32;
   localparam int unsigned T_FRAC_BITS_DEF = 16;

   // Fixed field widths
   localparam int unsigned TAG_BITS = 16;
   localparam int unsigned DIR_BITS = 16;
   localparam int unsigned DIR_FRAC = 14;
   localparam int unsigned EPS_BITS = 16;

   // Scaled quadratic coefficients stay below 2^SC_LIMIT in magnitude
   localparam int unsigned SC_LIMIT  = 30;
   localparam int unsigned SC_BITS   = SC_LIMIT + 1;
   localparam int unsigned DISC_BITS = 2 * SC_BITS + 2;
   localparam int unsigned ROOT_BITS = DISC_BITS / 2;

   // Divisor width after normalization for the t quantizer
   localparam int unsigned DEN_BITS = 31;

   // Configuration port
   localparam int unsigned CSR_IDX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_USE_AXIS    = 3'd0,
      REG_AXIS_SELECT = 3'd1,
      REG_DIR_X       = 3'd2,
      REG_DIR_Y       = 3'd3,
      REG_EPSILON     = 3'd4
   } csr_reg_type;

   // Register reset values
   localparam logic                       USE_AXIS_RST    = 1'b0;
   localparam logic                       AXIS_SELECT_RST = 1'b0;
   localparam logic signed [DIR_BITS-1:0] DIR_X_RST       = 16'sd16384;
   localparam logic signed [DIR_BITS-1:0] DIR_Y_RST       = 16'sd0;
   localparam logic        [EPS_BITS-1:0] EPSILON_RST     = 16'd1;

endpackage

// ===== src/cbe_if.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier extrema channel interfaces
// Segment request, extremum response and register write channels.
// ----------------------------------------------------------------------------
interface cbe_req_if #(
   parameter int unsigned COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [cbe_pkg::TAG_BITS-1:0]      segment_tag;
   logic                              is_cubic;
   logic signed [COORD_WIDTH-1:0]     p0_x;
   logic signed [COORD_WIDTH-1:0]     p0_y;
   logic signed [COORD_WIDTH-1:0]     p1_x;
   logic signed [COORD_WIDTH-1:0]     p1_y;
   logic signed [COORD_WIDTH-1:0]     p2_x;
   logic signed [COORD_WIDTH-1:0]     p2_y;
   logic signed [COORD_WIDTH-1:0]     p3_x;
   logic signed [COORD_WIDTH-1:0]     p3_y;

   modport source (
      output valid, segment_tag, is_cubic, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
      input  ready
   );
   modport sink (
      input  valid, segment_tag, is_cubic, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
      output ready
   );
endinterface

interface cbe_rsp_if #(
   parameter int unsigned T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [cbe_pkg::TAG_BITS-1:0]  result_tag;
   logic [T_FRAC_BITS-1:0]        t_param;
   logic                          last;

   modport source (output valid, result_tag, t_param, last, input ready);
   modport sink (input valid, result_tag, t_param, last, output ready);
endinterface

interface cbe_csr_if;
   logic                                valid;
   logic                                ready;
   logic [cbe_pkg::CSR_IDX_BITS-1:0]    index;
   logic [cbe_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cubic_bezier_extrema_finder.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier extrema finder
// One segment per cycle unless stalled; returns up to two extremum t values.
// ----------------------------------------------------------------------------
// A segment is accepted in every cycle that the result side keeps up with.
// Seven stages form the projection, coefficients, scaling and discriminant,
// ROOT_BITS (32) stages take the square root one bit each, three stages
// pick and normalize the roots and T_FRAC_BITS + 1 stages divide out t one
// quotient bit each, for both roots side by side. A segment with two extrema
// puts two beats on the result port, so the input stalls if a later segment
// with extrema reaches the output meanwhile; segments with none or one go
// through at full rate. Register writes are taken at any time with ready
// held high. That they take effect on segments accepted after the pipeline
// drains is the user's to ensure; the block does not enforce it.
// ----------------------------------------------------------------------------
module cubic_bezier_extrema_finder #(
   parameter int unsigned COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF,
   parameter int unsigned T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cbe_csr_if.sink   csr_ch,
   cbe_req_if.sink   req_ch,
   cbe_rsp_if.source rsp_ch
);
   import cbe_pkg::*;

   // Derived widths
   localparam int unsigned CW  = COORD_WIDTH;
   localparam int unsigned PW  = CW + DIR_BITS;
   localparam int unsigned XW  = CW + 3;
   localparam int unsigned CFW = CW + 7;
   localparam int unsigned MW  = (CFW > SC_LIMIT) ? CFW : SC_LIMIT + 1;
   localparam int unsigned KW  = $clog2(MW - SC_LIMIT + 1);
   localparam int unsigned QW  = (CFW > DEN_BITS + 1) ? CFW : DEN_BITS + 1;
   localparam int unsigned SW  = $clog2(QW - DEN_BITS + 1);
   localparam int unsigned QB  = T_FRAC_BITS + 1;
   localparam int unsigned NW  = DEN_BITS + T_FRAC_BITS + 1;
   localparam int unsigned NUMW = ROOT_BITS + 2;
   localparam int unsigned RW  = ROOT_BITS;
   localparam logic signed [PW:0] RND = (PW + 1)'(2 ** (DIR_FRAC - 1));

   typedef struct packed {
      logic [TAG_BITS-1:0]       tag;
      logic                      use_lin;
      logic                      lin_ok;
      logic                      dneg;
      logic [QW-1:0]             lin_num;
      logic [QW-1:0]             lin_den;
      logic signed [SC_BITS-1:0] sa;
      logic signed [SC_BITS-1:0] sb;
   } side_type;

   typedef struct packed {
      logic [RW+1:0]   rem;
      logic [RW-1:0]   root;
      logic [2*RW-1:0] dsh;
   } sqrt_type;

   typedef struct packed {
      logic [NW-1:0]       n;
      logic [DEN_BITS-1:0] d;
      logic [DEN_BITS-1:0] r;
      logic [QB-1:0]       q;
   } div_type;

   // --------------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------------
   logic                       use_axis_ff;
   logic                       axis_select_ff;
   logic signed [DIR_BITS-1:0] dir_x_ff;
   logic signed [DIR_BITS-1:0] dir_y_ff;
   logic [EPS_BITS-1:0]        epsilon_ff;

   assign csr_ch.ready = 1'b1;

   // Write one register per beat; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         use_axis_ff    <= USE_AXIS_RST;
         axis_select_ff <= AXIS_SELECT_RST;
         dir_x_ff       <= DIR_X_RST;
         dir_y_ff       <= DIR_Y_RST;
         epsilon_ff     <= EPSILON_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_reg_type'(csr_ch.index))
            REG_USE_AXIS:    use_axis_ff    <= csr_ch.data[0];
            REG_AXIS_SELECT: axis_select_ff <= csr_ch.data[0];
            REG_DIR_X:       dir_x_ff       <= DIR_BITS'(csr_ch.data);
            REG_DIR_Y:       dir_y_ff       <= DIR_BITS'(csr_ch.data);
            REG_EPSILON:     epsilon_ff     <= EPS_BITS'(csr_ch.data);
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // Pipeline advance
   // --------------------------------------------------------------------------
   logic adv;
   logic ob_take;
   logic ob_valid_ff;
   logic ob_idx_ff;
   logic ob_two_ff;
   logic [TAG_BITS-1:0]    ob_tag_ff;
   logic [T_FRAC_BITS-1:0] ob_t0_ff;
   logic [T_FRAC_BITS-1:0] ob_t1_ff;
   logic                   rsp_last;

   logic      dvv_ff [QB];
   logic [1:0] dvf_ff [QB];

   assign rsp_last = ob_idx_ff | ~ob_two_ff;
   assign ob_take  = ~ob_valid_ff | (rsp_ch.ready & rsp_last);
   assign adv      = ~dvv_ff[QB-1] | ~(|dvf_ff[QB-1]) | ob_take;
   assign req_ch.ready = adv;

   // --------------------------------------------------------------------------
   // Stage 1: direction products and axis pick
   // --------------------------------------------------------------------------
   logic signed [CW-1:0] crd [8];
   logic signed [PW-1:0] prod1_in [8];
   logic signed [CW-1:0] ax1_in [4];
   logic signed [PW-1:0] prod1_ff [8];
   logic signed [CW-1:0] ax1_ff [4];
   logic [TAG_BITS-1:0]  tag1_ff;
   logic                 v1_ff;

   assign crd[0] = req_ch.p0_x;
   assign crd[1] = req_ch.p0_y;
   assign crd[2] = req_ch.p1_x;
   assign crd[3] = req_ch.p1_y;
   assign crd[4] = req_ch.p2_x;
   assign crd[5] = req_ch.p2_y;
   assign crd[6] = req_ch.p3_x;
   assign crd[7] = req_ch.p3_y;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         prod1_in[i] = PW'(crd[i]) * PW'((i % 2 == 0) ? dir_x_ff : dir_y_ff);
      end
      for (int i = 0; i < 4; i++) begin
         ax1_in[i] = axis_select_ff ? crd[2*i+1] : crd[2*i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_ch.valid & req_ch.is_cubic;
      if (adv) begin
         prod1_ff <= prod1_in;
         ax1_ff   <= ax1_in;
         tag1_ff  <= req_ch.segment_tag;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 2: round products and form the scalar control values
   // --------------------------------------------------------------------------
   logic signed [PW:0]   rx [4];
   logic signed [PW:0]   ry [4];
   logic signed [XW-1:0] x2_in [4];
   logic signed [XW-1:0] x2_ff [4];
   logic [TAG_BITS-1:0]  tag2_ff;
   logic                 v2_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rx[i] = (PW + 1)'(prod1_ff[2*i]) + RND;
         ry[i] = (PW + 1)'(prod1_ff[2*i+1]) + RND;
         x2_in[i] = use_axis_ff ? XW'(ax1_ff[i])
                                : XW'(rx[i] >>> DIR_FRAC) + XW'(ry[i] >>> DIR_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         x2_ff   <= x2_in;
         tag2_ff <= tag1_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 3: derivative coefficients of the reversed curve
   // --------------------------------------------------------------------------
   logic signed [CFW-1:0] d21, e3, a3_in, b3_in, c3_in;
   logic signed [CFW-1:0] a3_ff, b3_ff, c3_ff;
   logic [TAG_BITS-1:0]   tag3_ff;
   logic                  v3_ff;

   always_comb begin
      d21   = CFW'(x2_ff[2]) - CFW'(x2_ff[1]);
      a3_in = CFW'(x2_ff[0]) - CFW'(x2_ff[3]) + (d21 <<< 1) + d21;
      e3    = CFW'(x2_ff[1]) + CFW'(x2_ff[3]) - (CFW'(x2_ff[2]) <<< 1);
      b3_in = e3 <<< 1;
      c3_in = CFW'(x2_ff[2]) - CFW'(x2_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         c3_ff   <= c3_in;
         tag3_ff <= tag2_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 4: magnitudes, epsilon tests and common scale shift
   // --------------------------------------------------------------------------
   logic [CFW-1:0] ma, mb, mc;
   logic [MW-1:0]  orm;
   logic [KW-1:0]  k4_in;
   logic signed [CFW-1:0] a4_ff, b4_ff, c4_ff;
   logic [CFW-1:0] mb4_ff;
   logic [KW-1:0]  k4_ff;
   logic           asmall4_ff, bbig4_ff;
   logic [TAG_BITS-1:0] tag4_ff;
   logic           v4_ff;

   always_comb begin
      ma  = a3_ff[CFW-1] ? CFW'(-a3_ff) : CFW'(a3_ff);
      mb  = b3_ff[CFW-1] ? CFW'(-b3_ff) : CFW'(b3_ff);
      mc  = c3_ff[CFW-1] ? CFW'(-c3_ff) : CFW'(c3_ff);
      orm = MW'(ma) | MW'(mb) | MW'(mc);
      // Count the bit positions at or above the limit that are reached
      k4_in = '0;
      for (int j = 0; j < int'(MW - SC_LIMIT); j++) begin
         k4_in = k4_in + KW'(|(orm >> (SC_LIMIT + j)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         a4_ff      <= a3_ff;
         b4_ff      <= b3_ff;
         c4_ff      <= c3_ff;
         mb4_ff     <= mb;
         k4_ff      <= k4_in;
         asmall4_ff <= ma < CFW'(epsilon_ff);
         bbig4_ff   <= mb > CFW'(epsilon_ff);
         tag4_ff    <= tag3_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 5: scale coefficients and set up the linear root
   // --------------------------------------------------------------------------
   logic signed [CFW-1:0]     ln;
   logic                      lok5_in;
   logic signed [SC_BITS-1:0] sa5_ff, sb5_ff, sc5_ff;
   logic                      asmall5_ff, lok5_ff;
   logic [QW-1:0]             lnum5_ff, lden5_ff;
   logic [TAG_BITS-1:0]       tag5_ff;
   logic                      v5_ff;

   always_comb begin
      ln      = b4_ff[CFW-1] ? c4_ff : -c4_ff;
      lok5_in = bbig4_ff & ~ln[CFW-1] & (ln != '0) & ($unsigned(ln) < mb4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         sa5_ff     <= SC_BITS'(a4_ff >>> k4_ff);
         sb5_ff     <= SC_BITS'(b4_ff >>> k4_ff);
         sc5_ff     <= SC_BITS'(c4_ff >>> k4_ff);
         asmall5_ff <= asmall4_ff;
         lok5_ff    <= lok5_in;
         lnum5_ff   <= QW'(mb4_ff - $unsigned(ln));
         lden5_ff   <= QW'(mb4_ff);
         tag5_ff    <= tag4_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 6: discriminant products
   // --------------------------------------------------------------------------
   logic signed [2*SC_BITS-1:0] sq6_ff, pr6_ff;
   side_type                    side6_in, side6_ff;
   logic                        v6_ff;

   always_comb begin
      side6_in.tag     = tag5_ff;
      side6_in.use_lin = asmall5_ff | (sa5_ff == '0);
      side6_in.lin_ok  = lok5_ff;
      side6_in.dneg    = 1'b0;
      side6_in.lin_num = lnum5_ff;
      side6_in.lin_den = lden5_ff;
      side6_in.sa      = sa5_ff;
      side6_in.sb      = sb5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         sq6_ff   <= (2*SC_BITS)'(sb5_ff) * (2*SC_BITS)'(sb5_ff);
         pr6_ff   <= (2*SC_BITS)'(sa5_ff) * (2*SC_BITS)'(sc5_ff);
         side6_ff <= side6_in;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 7: discriminant
   // --------------------------------------------------------------------------
   logic signed [DISC_BITS-1:0] disc7_in;
   logic [2*RW-1:0]             disc7_ff;
   side_type                    side7_in, side7_ff;
   logic                        v7_ff;

   always_comb begin
      disc7_in      = DISC_BITS'(sq6_ff) - (DISC_BITS'(pr6_ff) <<< 2);
      side7_in      = side6_ff;
      side7_in.dneg = disc7_in[DISC_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         disc7_ff <= (2*RW)'(disc7_in);
         side7_ff <= side7_in;
      end
   end

   // --------------------------------------------------------------------------
   // Square root: one result bit per stage
   // --------------------------------------------------------------------------
   sqrt_type sq_ff  [RW];
   side_type sqs_ff [RW];
   logic     sqv_ff [RW];
   sqrt_type sq_init;

   always_comb begin
      sq_init.rem  = '0;
      sq_init.root = '0;
      sq_init.dsh  = disc7_ff;
   end

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      sqrt_type src;
      sqrt_type sq_in;
      side_type sside;
      logic     sval;
      logic [RW+1:0] rem2, trial;
      logic     ge;

      if (i == 0) begin : g_first
         assign src   = sq_init;
         assign sside = side7_ff;
         assign sval  = v7_ff;
      end else begin : g_next
         assign src   = sq_ff[i-1];
         assign sside = sqs_ff[i-1];
         assign sval  = sqv_ff[i-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rem2        = {src.rem[RW-1:0], src.dsh[2*RW-1 -: 2]};
         trial       = {src.root, 2'b01};
         ge          = rem2 >= trial;
         sq_in.rem   = ge ? rem2 - trial : rem2;
         sq_in.root  = {src.root[RW-2:0], ge};
         sq_in.dsh   = {src.dsh[2*RW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) sqv_ff[i] <= 1'b0;
         else if (adv) sqv_ff[i] <= sval;
         if (adv) begin
            sq_ff[i]  <= sq_in;
            sqs_ff[i] <= sside;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stage 8: both roots, range tests and choice of linear or quadratic
   // --------------------------------------------------------------------------
   side_type               s8;
   logic [RW-1:0]          r8;
   logic signed [SC_BITS:0] sa2;
   logic [SC_BITS:0]       dq;
   logic signed [NUMW-1:0] nump, numm, np, nm;
   logic                   vp, vm;
   logic [QW-1:0]          n8_in [2];
   logic [QW-1:0]          d8_in [2];
   logic [1:0]             f8_in;
   logic [QW-1:0]          n8_ff [2];
   logic [QW-1:0]          d8_ff [2];
   logic [1:0]             f8_ff;
   logic [TAG_BITS-1:0]    tag8_ff;
   logic                   v8_ff;

   always_comb begin
      s8   = sqs_ff[RW-1];
      r8   = sq_ff[RW-1].root;
      sa2  = {s8.sa, 1'b0};
      dq   = s8.sa[SC_BITS-1] ? $unsigned(-sa2) : $unsigned(sa2);
      nump = -NUMW'(s8.sb) + NUMW'(r8);
      numm = -NUMW'(s8.sb) - NUMW'(r8);
      np   = s8.sa[SC_BITS-1] ? -nump : nump;
      nm   = s8.sa[SC_BITS-1] ? -numm : numm;
      vp   = ~np[NUMW-1] & (np != '0) & ($unsigned(np) < NUMW'(dq));
      vm   = ~nm[NUMW-1] & (nm != '0) & ($unsigned(nm) < NUMW'(dq));
      if (s8.use_lin) begin
         n8_in[0] = s8.lin_num;
         d8_in[0] = s8.lin_den;
         n8_in[1] = '0;
         d8_in[1] = '0;
         f8_in    = {1'b0, s8.lin_ok};
      end else begin
         n8_in[0] = QW'(dq - np[SC_BITS:0]);
         d8_in[0] = QW'(dq);
         n8_in[1] = QW'(dq - nm[SC_BITS:0]);
         d8_in[1] = QW'(dq);
         f8_in    = {vm & ~s8.dneg, vp & ~s8.dneg};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= sqv_ff[RW-1];
      if (adv) begin
         n8_ff   <= n8_in;
         d8_ff   <= d8_in;
         f8_ff   <= f8_in;
         tag8_ff <= s8.tag;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 9: shift that brings each divisor below 2^DEN_BITS
   // --------------------------------------------------------------------------
   logic [SW-1:0]       s9_in [2];
   logic [SW-1:0]       s9_ff [2];
   logic [QW-1:0]       n9_ff [2];
   logic [QW-1:0]       d9_ff [2];
   logic [1:0]          f9_ff;
   logic [TAG_BITS-1:0] tag9_ff;
   logic                v9_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s9_in[l] = '0;
         for (int j = 0; j < int'(QW - DEN_BITS); j++) begin
            s9_in[l] = s9_in[l] + SW'(|(d8_ff[l] >> (DEN_BITS + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= v8_ff;
      if (adv) begin
         s9_ff   <= s9_in;
         n9_ff   <= n8_ff;
         d9_ff   <= d8_ff;
         f9_ff   <= f8_ff;
         tag9_ff <= tag8_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage 10: normalize and form the rounded dividend
   // --------------------------------------------------------------------------
   logic [QW-1:0]       ns10 [2];
   logic [QW-1:0]       ds10 [2];
   div_type             dv10_in [2];
   div_type             dv10_ff [2];
   logic [1:0]          f10_ff;
   logic [TAG_BITS-1:0] tag10_ff;
   logic                v10_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ns10[l]      = n9_ff[l] >> s9_ff[l];
         ds10[l]      = d9_ff[l] >> s9_ff[l];
         dv10_in[l].n = NW'({ns10[l][DEN_BITS-1:0], {T_FRAC_BITS{1'b0}}})
                      + NW'(ds10[l][DEN_BITS-1:1]);
         dv10_in[l].d = ds10[l][DEN_BITS-1:0];
         dv10_in[l].r = '0;
         dv10_in[l].q = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (adv) v10_ff <= v9_ff;
      if (adv) begin
         dv10_ff  <= dv10_in;
         f10_ff   <= f9_ff;
         tag10_ff <= tag9_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Divider: one quotient bit per stage, both roots in parallel
   // --------------------------------------------------------------------------
   div_type             dv_ff  [QB][2];
   logic [TAG_BITS-1:0] dvt_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_div
      div_type             src [2];
      div_type             dv_in [2];
      logic [1:0]          fsrc;
      logic [TAG_BITS-1:0] tsrc;
      logic                vsrc;
      logic [DEN_BITS:0]   tr [2];
      logic                ge [2];

      if (j == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               src[l]   = dv10_ff[l];
               src[l].r = dv10_ff[l].n[NW-1:QB];
            end
         end
         assign fsrc = f10_ff;
         assign tsrc = tag10_ff;
         assign vsrc = v10_ff;
      end else begin : g_next
         assign src  = dv_ff[j-1];
         assign fsrc = dvf_ff[j-1];
         assign tsrc = dvt_ff[j-1];
         assign vsrc = dvv_ff[j-1];
      end

      // Shift in the next dividend bit and subtract when it fits
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            tr[l]    = {src[l].r, src[l].n[QB-1-j]};
            ge[l]    = tr[l] >= {1'b0, src[l].d};
            dv_in[l] = src[l];
            dv_in[l].r = ge[l] ? DEN_BITS'(tr[l] - {1'b0, src[l].d})
                               : tr[l][DEN_BITS-1:0];
            dv_in[l].q[QB-1-j] = ge[l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dvv_ff[j] <= 1'b0;
         else if (adv) dvv_ff[j] <= vsrc;
         if (adv) begin
            dv_ff[j]  <= dv_in;
            dvf_ff[j] <= fsrc;
            dvt_ff[j] <= tsrc;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Clamp t and hold the result beats
   // --------------------------------------------------------------------------
   logic [T_FRAC_BITS-1:0] tq [2];
   logic                   ob_load;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (dv_ff[QB-1][l].q == '0) begin
            tq[l] = T_FRAC_BITS'(1);
         end else if (dv_ff[QB-1][l].q[T_FRAC_BITS]) begin
            tq[l] = '1;
         end else begin
            tq[l] = dv_ff[QB-1][l].q[T_FRAC_BITS-1:0];
         end
      end
   end

   assign ob_load = adv & dvv_ff[QB-1] & (|dvf_ff[QB-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_idx_ff   <= 1'b0;
      end else if (ob_load) begin
         ob_valid_ff <= 1'b1;
         ob_idx_ff   <= 1'b0;
      end else if (ob_valid_ff && rsp_ch.ready) begin
         // Advance to the second beat or drop the finished segment
         if (rsp_last) ob_valid_ff <= 1'b0;
         else          ob_idx_ff   <= 1'b1;
      end
      if (ob_load) begin
         ob_two_ff <= &dvf_ff[QB-1];
         ob_tag_ff <= dvt_ff[QB-1];
         ob_t0_ff  <= dvf_ff[QB-1][0] ? tq[0] : tq[1];
         ob_t1_ff  <= tq[1];
      end
   end

   assign rsp_ch.valid      = ob_valid_ff;
   assign rsp_ch.result_tag = ob_tag_ff;
   assign rsp_ch.t_param    = ob_idx_ff ? ob_t1_ff : ob_t0_ff;
   assign rsp_ch.last       = rsp_last;

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   a_t_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.t_param != '0)
      else $error("extremum beat with t of zero");

   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last |=>
         rsp_ch.valid && rsp_ch.result_tag == $past(rsp_ch.result_tag))
      else $error("first extremum of a pair not followed by its partner");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> ob_valid_ff && dvv_ff[QB-1])
      else $error("input stalled with no result waiting");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      dvv_ff[QB-1] && dvf_ff[QB-1][0] |-> dv_ff[QB-1][0].r < dv_ff[QB-1][0].d)
      else $error("divider remainder not below divisor");

endmodule

// ===== test/cbe_extrema_checker.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier extrema checker
// Watches the register, segment and extremum channels, predicts the extremum
// beats of each accepted segment and compares them in order.
// ----------------------------------------------------------------------------
module cbe_extrema_checker (
   input  logic        clock,
   input  logic        reset,
   cbe_csr_if          csr_mon,
   cbe_req_if          req_mon,
   cbe_rsp_if          rsp_mon,
   output int          fail_count,
   output int          pending_count
);
   import cbe_pkg::*;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [15:0]         t;
      logic                last;
   } extremum_type;

   extremum_type expected_extrema[$];

   // Shadow register copy
   logic                       axis_mode;
   logic                       axis_y;
   logic signed [DIR_BITS-1:0] dir_x_q;
   logic signed [DIR_BITS-1:0] dir_y_q;
   logic [EPS_BITS-1:0]        eps_q;

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint root_floor(longint v);
      longint r, bit_v;
      r = 0;
      bit_v = 64'sd1 <<< 62;
      while (bit_v > v) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >>> 1) + bit_v;
         end else begin
            r = r >>> 1;
         end
         bit_v = bit_v >>> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] quantize_t(longint num, longint den);
      longint q;
      while (den >= (64'sd1 <<< 31)) begin
         num = num >>> 1;
         den = den >>> 1;
      end
      q = ((num <<< 16) + den / 2) / den;
      if (q < 1) q = 1;
      if (q > 65535) q = 65535;
      return q[15:0];
   endfunction

   function automatic longint project_point(logic signed [31:0] px, logic signed [31:0] py);
      longint sx, sy;
      sx = px;
      sy = py;
      if (axis_mode) return axis_y ? sy : sx;
      return floor_shift(sx * longint'(dir_x_q) + 8192, 14)
           + floor_shift(sy * longint'(dir_y_q) + 8192, 14);
   endfunction

   // Linear root of b*s + c; returns count (0 or 1)
   function automatic int linear_root(longint b, longint c, output logic [15:0] t);
      longint n, d;
      t = '0;
      if (magnitude(b) <= longint'(eps_q)) return 0;
      n = -c;
      d = b;
      if (d < 0) begin
         n = c;
         d = -b;
      end
      if (n > 0 && n < d) begin
         t = quantize_t(d - n, d);
         return 1;
      end
      return 0;
   endfunction

   task automatic predict_extrema(logic [TAG_BITS-1:0] tag, longint x0, longint x1,
                                  longint x2, longint x3);
      longint a, b, c, m, sa, sb, sc, dsc, r, num, d;
      logic [15:0] ts[2];
      int n, k;
      extremum_type item;
      n = 0;
      a = x0 - 3 * x1 + 3 * x2 - x3;
      b = 2 * (x1 - 2 * x2 + x3);
      c = x2 - x3;
      if (magnitude(a) < longint'(eps_q)) begin
         n = linear_root(b, c, ts[0]);
      end else begin
         m = magnitude(a);
         if (magnitude(b) > m) m = magnitude(b);
         if (magnitude(c) > m) m = magnitude(c);
         k = 0;
         while ((m >>> k) >= (64'sd1 <<< 30)) k++;
         sa = floor_shift(a, k);
         sb = floor_shift(b, k);
         sc = floor_shift(c, k);
         if (sa == 0) begin
            n = linear_root(b, c, ts[0]);
         end else begin
            dsc = sb * sb - 4 * sa * sc;
            if (dsc >= 0) begin
               r = root_floor(dsc);
               for (int p = 0; p < 2; p++) begin
                  num = (p == 0) ? -sb + r : -sb - r;
                  d = 2 * sa;
                  if (d < 0) begin
                     num = -num;
                     d = -d;
                  end
                  if (num > 0 && num < d) begin
                     ts[n] = quantize_t(d - num, d);
                     n++;
                  end
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         item.tag  = tag;
         item.t    = ts[i];
         item.last = (i == n - 1);
         expected_extrema.insert(expected_extrema.size(), item);
      end
   endtask

   always @(posedge clock) begin
      extremum_type exp_x;
      if (reset) begin
         axis_mode <= USE_AXIS_RST;
         axis_y    <= AXIS_SELECT_RST;
         dir_x_q   <= DIR_X_RST;
         dir_y_q   <= DIR_Y_RST;
         eps_q     <= EPSILON_RST;
         fail_count <= 0;
         expected_extrema.delete();
      end else begin
         // Track register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_reg_type'(csr_mon.index))
               REG_USE_AXIS:    axis_mode <= csr_mon.data[0];
               REG_AXIS_SELECT: axis_y    <= csr_mon.data[0];
               REG_DIR_X:       dir_x_q   <= csr_mon.data;
               REG_DIR_Y:       dir_y_q   <= csr_mon.data;
               REG_EPSILON:     eps_q     <= csr_mon.data;
               default: ;
            endcase
         end
         // Predict on each segment beat
         if (req_mon.valid && req_mon.ready && req_mon.is_cubic)
            predict_extrema(req_mon.segment_tag,
                            project_point(req_mon.p0_x, req_mon.p0_y),
                            project_point(req_mon.p1_x, req_mon.p1_y),
                            project_point(req_mon.p2_x, req_mon.p2_y),
                            project_point(req_mon.p3_x, req_mon.p3_y));
         // Compare each extremum beat with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_extrema.size() == 0) begin
               $error("unexpected extremum beat tag=%0h t=%0h", rsp_mon.result_tag,
                      rsp_mon.t_param);
               fail_count <= fail_count + 1;
            end else begin
               exp_x = expected_extrema.pop_front();
               if (rsp_mon.result_tag !== exp_x.tag ||
                   rsp_mon.t_param !== exp_x.t || rsp_mon.last !== exp_x.last)
                  fail_count <= fail_count + 1;
               if (rsp_mon.result_tag !== exp_x.tag)
                  $error("result_tag expected %0h got %0h", exp_x.tag, rsp_mon.result_tag);
               if (rsp_mon.t_param !== exp_x.t)
                  $error("t_param expected %0h got %0h", exp_x.t, rsp_mon.t_param);
               if (rsp_mon.last !== exp_x.last)
                  $error("last expected %0b got %0b", exp_x.last, rsp_mon.last);
            end
         end
      end
      // Publish the number of outstanding beats
      pending_count <= expected_extrema.size();
   end

endmodule

// ===== test/cubic_bezier_extrema_finder_tb.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier extrema finder testbench
// Drives directed and random segments under several register settings with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module cubic_bezier_extrema_finder_tb;
   import cbe_pkg::*;

   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT   = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;
   int   segs_sent = 0;
   bit   rsp_pattern_on = 1'b1;

   cbe_csr_if csr_ch ();
   cbe_req_if req_ch ();
   cbe_rsp_if rsp_ch ();

   cubic_bezier_extrema_finder dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cbe_extrema_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_mon       (csr_ch),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   initial begin
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      req_ch.valid = 1'b0;
      req_ch.segment_tag = '0;
      req_ch.is_cubic = 1'b0;
      {req_ch.p0_x, req_ch.p0_y, req_ch.p1_x, req_ch.p1_y} = '0;
      {req_ch.p2_x, req_ch.p2_y, req_ch.p3_x, req_ch.p3_y} = '0;
      rsp_ch.ready = 1'b0;
   end

   // Receiver stall pattern: phases of free flow, random and heavy stalls
   always @(negedge clock) begin
      int phase;
      phase = (segs_sent / 150) % 3;
      if (!rsp_pattern_on || phase == 0) rsp_ch.ready <= 1'b1;
      else if (phase == 1)               rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else                               rsp_ch.ready <= ($urandom_range(0, 2) == 0);
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(csr_reg_type idx, logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Hold valid until the segment beat is taken; valid stays up across beats
   task automatic send_segment(logic cubic, logic [31:0] pts[8]);
      req_ch.valid       <= 1'b1;
      req_ch.segment_tag <= 16'($urandom);
      req_ch.is_cubic    <= cubic;
      req_ch.p0_x <= pts[0]; req_ch.p0_y <= pts[1];
      req_ch.p1_x <= pts[2]; req_ch.p1_y <= pts[3];
      req_ch.p2_x <= pts[4]; req_ch.p2_y <= pts[5];
      req_ch.p3_x <= pts[6]; req_ch.p3_y <= pts[7];
      do @(posedge clock); while (!req_ch.ready);
      segs_sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int style);
      case (style)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return 32'($signed($urandom_range(0, 200000)) - 100000);
         default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   task automatic random_segments(int count);
      logic [31:0] pts[8];
      int style, burst;
      burst = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
         style = $urandom_range(0, 9);
         style = (style < 2) ? 0 : (style < 6) ? 1 : (style < 9) ? 2 : 3;
         foreach (pts[j]) pts[j] = ($urandom_range(0, 19) == 0) ? rand_coord(3)
                                                                 : rand_coord(style);
         send_segment($urandom_range(0, 9) != 0, pts);
         if (--burst == 0) begin
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
            burst = $urandom_range(1, 20);
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   task automatic directed_segments();
      logic [31:0] pts[8];
      // Extremes of every coordinate
      foreach (pts[j]) pts[j] = 32'h7fff_ffff;
      send_segment(1'b1, pts);
      foreach (pts[j]) pts[j] = 32'h8000_0000;
      send_segment(1'b1, pts);
      foreach (pts[j]) pts[j] = (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_segment(1'b1, pts);
      pts = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
      send_segment(1'b1, pts);
      // Two extrema: S-shaped x profile
      pts = '{0, 0, 32'h0003_0000, 0, 32'hfffd_0000, 0, 32'h0001_0000, 0};
      send_segment(1'b1, pts);
      // One extremum: arch
      pts = '{0, 0, 32'h0002_0000, 0, 32'h0002_0000, 0, 0, 0};
      send_segment(1'b1, pts);
      // One extremum: the other root of the quadratic lies outside the segment
      pts = '{0, 0, 32'h0004_0000, 0, 32'h0004_0000, 0, 32'hfffc_0000, 0};
      send_segment(1'b1, pts);
      // Straight line: no extremum
      pts = '{0, 0, 32'h0001_0000, 0, 32'h0002_0000, 0, 32'h0003_0000, 0};
      send_segment(1'b1, pts);
      // Constant: slope below epsilon too
      foreach (pts[j]) pts[j] = 32'h0001_0000;
      send_segment(1'b1, pts);
      // A tiny curve near epsilon, then a curve with one extremum
      pts = '{0, 0, 1, 0, 32'hffff_ffff, 0, 2, 0};
      send_segment(1'b1, pts);
      pts = '{0, 0, 32'h0001_0000, 0, 32'h0002_0000, 0, 32'h0001_0000, 0};
      send_segment(1'b1, pts);
      // Non-cubic segment with extremum geometry
      pts = '{0, 0, 32'h0003_0000, 0, 32'hfffd_0000, 0, 32'h0001_0000, 0};
      send_segment(1'b0, pts);
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      directed_segments();
      wait_drained();

      // Phase: axis y, large epsilon
      write_reg(REG_USE_AXIS, 16'd1);
      write_reg(REG_AXIS_SELECT, 16'd1);
      write_reg(REG_EPSILON, 16'hffff);
      directed_segments();
      random_segments(250);
      wait_drained();

      // Phase: axis x, zero epsilon
      write_reg(REG_AXIS_SELECT, 16'd0);
      write_reg(REG_EPSILON, 16'd0);
      random_segments(300);
      wait_drained();

      // Phase: diagonal projection
      write_reg(REG_USE_AXIS, 16'd0);
      write_reg(REG_DIR_X, 16'd11585);
      write_reg(REG_DIR_Y, 16'd11585);
      write_reg(REG_EPSILON, 16'd1);
      random_segments(300);
      // Hold the sender until every extremum is back
      rsp_pattern_on = 1'b0;
      wait_drained();
      rsp_pattern_on = 1'b1;
      random_segments(150);
      wait_drained();

      // Phase: direction extremes
      write_reg(REG_DIR_X, 16'hc000);
      write_reg(REG_DIR_Y, 16'h4000);
      write_reg(REG_EPSILON, 16'd300);
      random_segments(300);
      wait_drained();

      write_reg(REG_DIR_X, 16'h8000);
      write_reg(REG_DIR_Y, 16'h7fff);
      random_segments(300);
      wait_drained();

      // Random registers, including out-of-range directions
      for (int p = 0; p < 3; p++) begin
         write_reg(REG_USE_AXIS, 16'($urandom_range(0, 1)));
         write_reg(REG_AXIS_SELECT, 16'($urandom_range(0, 1)));
         write_reg(REG_DIR_X, 16'($urandom));
         write_reg(REG_DIR_Y, 16'($urandom));
         write_reg(REG_EPSILON,
                   16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4)));
         random_segments(100);
         wait_drained();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
